// ===== design/boot_keyboard_report_to_ascii_fifo_macros.svh =====
// Assertion macros used by the checker file.
`ifndef BOOT_KEYBOARD_REPORT_TO_ASCII_FIFO_MACROS_SVH
`define BOOT_KEYBOARD_REPORT_TO_ASCII_FIFO_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BKASC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bkasc assertion failed");

// Next-cycle implication, disabled during reset.
`define BKASC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bkasc assertion failed");

`endif

// ===== design/bkasc_pkg.sv =====
package bkasc_pkg;

  localparam int BKASC_FIFO_DEPTH = 64;
  localparam int NUM_KEYS = 6;
  localparam int MAP_LEN = 57;

  localparam logic [7:0] MOD_CTRL_MASK = 8'h11;
  localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CTRL_OFFSET = 8'h60;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] PLAIN_MAP [0:MAP_LEN-1] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 8'h62, 8'h63, 8'h64,
    8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C,
    8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
    8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h0A, 8'h00, 8'h08, 8'h09, 8'h20, 8'h2D, 8'h3D, 8'h5B,
    8'h5D, 8'h5C, 8'h00, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E,
    8'h2F
  };

  localparam logic [7:0] SHIFT_MAP [0:MAP_LEN-1] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42, 8'h43, 8'h44,
    8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
    8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h21, 8'h40,
    8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
    8'h0A, 8'h00, 8'h08, 8'h09, 8'h20, 8'h5F, 8'h2B, 8'h7B,
    8'h7D, 8'h7C, 8'h00, 8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E,
    8'h3F
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== design/boot_keyboard_report_to_ascii_fifo.sv =====
// Report command: six lanes translate the keys at the input transfer, then one FIFO write
// slot per key follows, and then the result is registered to the output.
// Read command: the character memory is read at the input transfer, then the result is registered.
// One item at a time: a new command waits until the result is loaded to the output.
// Synchronous active-high reset empties the FIFO and clears all control state.
module boot_keyboard_report_to_ascii_fifo
  import bkasc_pkg::*;
#(
  parameter int FIFO_DEPTH = BKASC_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // modifiers[7:0], report_len[11:8], key_0..key_5 [59:12], zero fill [63:60]
  input  logic [63:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // char_valid[0], char_out[8:1], fifo_nonempty[9], stored_count[12:10],
  // dropped_count[15:13]
  output logic [15:0] m_tdata
);

  state_t state;
  state_t state_next;

  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;
  logic [7:0] rd_data;

  logic [7:0] lane_ch [0:NUM_KEYS-1];
  logic [7:0] lane_char [0:NUM_KEYS-1];
  logic [2:0] slot;
  logic [2:0] stored_count;
  logic [2:0] dropped_count;
  logic       char_valid;
  logic       in_xfer;
  logic       out_load;
  logic [7:0] cur_char;

  assign in_xfer = s_tvalid && s_tready;
  assign cur_char = lane_char[slot];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    bkasc_lane u_lane (
      .code      (s_tdata[12 + 8 * k +: 8]),
      .modifiers (s_tdata[7:0]),
      .slot_en   (s_tdata[11:8] > 4'(k + 2)),
      .ch        (lane_ch[k])
    );
  end

  bkasc_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fifo_ctrl),
    .stat    (fifo_stat),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (s_tuser == CMD_READ) ? S_DONE : S_PUSH;
        end
      end
      S_PUSH: begin
        if (slot == 3'(NUM_KEYS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    fifo_ctrl = '{push: 1'b0, pop: 1'b0, wdata: cur_char};
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        fifo_ctrl.pop = s_tvalid && (s_tuser == CMD_READ);
      end
      S_PUSH: begin
        fifo_ctrl.push = (cur_char != 8'h00);
      end
      S_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      slot <= '0;
      stored_count <= '0;
      dropped_count <= '0;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        slot <= '0;
        stored_count <= '0;
        dropped_count <= '0;
        char_valid <= (s_tuser == CMD_READ) && !fifo_stat.empty;
      end else if (state == S_PUSH) begin
        slot <= slot + 3'd1;
        if (cur_char != 8'h00) begin
          if (fifo_stat.full) begin
            dropped_count <= dropped_count + 3'd1;
          end else begin
            stored_count <= stored_count + 3'd1;
          end
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tuser == CMD_REPORT) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        lane_char[k] <= lane_ch[k];
      end
    end
    if (out_load) begin
      m_tdata <= {dropped_count, stored_count, !fifo_stat.empty,
                  char_valid ? rd_data : 8'h00, char_valid};
    end
  end

endmodule

// ===== design/bkasc_lane.sv =====
module bkasc_lane
  import bkasc_pkg::*;
(
  input  logic [7:0] code,
  input  logic [7:0] modifiers,
  input  logic       slot_en,
  output logic [7:0] ch
);

  logic [7:0] mapped;

  always_comb begin
    mapped = 8'h00;
    if (slot_en && code < 8'(MAP_LEN)) begin
      if ((modifiers & MOD_SHIFT_MASK) != 8'h00) begin
        mapped = SHIFT_MAP[code[5:0]];
      end else begin
        mapped = PLAIN_MAP[code[5:0]];
      end
    end
    ch = mapped;
    if ((modifiers & MOD_CTRL_MASK) != 8'h00 && mapped >= CHAR_LOWER_A &&
        mapped <= CHAR_LOWER_Z) begin
      ch = mapped - CTRL_OFFSET;
    end
  end

endmodule

// ===== design/bkasc_fifo.sv =====
module bkasc_fifo
  import bkasc_pkg::*;
#(
  parameter int FIFO_DEPTH = BKASC_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctrl_t ctrl,
  output fifo_stat_t stat,
  output logic [7:0] rd_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

  logic [7:0] mem [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] write_pointer_next;
  logic [PTR_W-1:0] read_pointer_next;

  assign write_pointer_next = (write_pointer == LAST_IDX) ? '0 : write_pointer + 1'b1;
  assign read_pointer_next = (read_pointer == LAST_IDX) ? '0 : read_pointer + 1'b1;

  assign stat.empty = (write_pointer == read_pointer);
  assign stat.full = (write_pointer_next == read_pointer);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer <= '0;
    end else begin
      if (ctrl.push && !stat.full) begin
        write_pointer <= write_pointer_next;
      end
      if (ctrl.pop && !stat.empty) begin
        read_pointer <= read_pointer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !stat.full) begin
      mem[write_pointer] <= ctrl.wdata;
    end
    if (ctrl.pop && !stat.empty) begin
      rd_data <= mem[read_pointer];
    end
  end

endmodule

// ===== design/bkasc_checker.sv =====
`include "boot_keyboard_report_to_ascii_fifo_macros.svh"

module bkasc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  `BKASC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BKASC_ASSERT_IMP(a_pop_nonzero, m_tvalid && m_tdata[0], m_tdata[8:1] != 8'h00)
  `BKASC_ASSERT_IMP(a_nopop_zero, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'h00)
  `BKASC_ASSERT_IMP(a_count_sum, m_tvalid,
                    ({1'b0, m_tdata[12:10]} + {1'b0, m_tdata[15:13]}) <= 4'd6)
  `BKASC_ASSERT_IMP(a_stored_nonempty, m_tvalid && m_tdata[12:10] != 3'd0, m_tdata[9])

endmodule

bind boot_keyboard_report_to_ascii_fifo bkasc_checker u_bkasc_checker (.*);
